FILE: sv/utf8d_pkg.sv
// Package: shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int CpWidth  = 31;
  localparam int CntWidth = 3;
  localparam logic [CntWidth-1:0] MaxErrItems = 3'd5;

  typedef struct packed {
    logic [CpWidth-1:0]  partial_value;
    logic [CntWidth-1:0] bytes_still_needed;
    logic [CntWidth-1:0] bytes_held;
  } u8d_state_t;

  // One decoded entry; count repeats it, last goes only on the final repeat.
  typedef struct packed {
    logic                valid;
    logic [CpWidth-1:0]  code_point;
    logic                malformed;
    logic                last;
    logic [CntWidth-1:0] count;
  } u8d_result_t;

endpackage

FILE: sv/utf8_stream_decoder_top.sv
// Top level: UTF-8 byte stream to code point stream decoder.
// A decoded result is registered in the output register, or in the skid entry if busy.
// Throughput: one byte per cycle while the skid entry is empty; a cut-short sequence
// repeats its error item up to five times, one per cycle while m_tready is high.
// Reset (rst, synchronous): clears the sequence state, both output stages and
// allow_long_sequences.
module utf8_stream_decoder_top import utf8d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // allow_long_sequences
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [7:0] in_byte
  input  logic        s_tlast,       // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,       // [30:0] code_point, [31] zero
  output logic        m_tuser,       // malformed
  output logic        m_tlast        // out_last
);

  logic        allow_long;
  u8d_state_t  state, state_next;
  u8d_result_t dec_res;
  u8d_result_t out_reg;
  u8d_result_t skid;
  logic        in_fire;
  logic        out_fire;
  logic        out_done;
  logic        out_free;

  utf8d_decode u_decode (
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .allow_long (allow_long),
    .cur        (state),
    .nxt        (state_next),
    .res        (dec_res)
  );

  assign s_tready = !skid.valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = out_reg.valid && m_tready;
  assign out_done = out_fire && (out_reg.count == 3'd1);
  assign out_free = !out_reg.valid || out_done;

  assign m_tvalid = out_reg.valid;
  assign m_tdata  = {1'b0, out_reg.code_point};
  assign m_tuser  = out_reg.malformed;
  assign m_tlast  = out_reg.last && (out_reg.count == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_long <= 1'b0;
    end else if (cfg_wr_en) begin
      allow_long <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg <= '0;
      skid    <= '0;
    end else begin
      if (out_free) begin
        if (skid.valid) begin
          out_reg <= skid;
          skid    <= '0;
        end else if (in_fire && dec_res.valid) begin
          out_reg <= dec_res;
        end else begin
          out_reg <= '0;
        end
      end else begin
        if (out_fire) begin
          out_reg.count <= out_reg.count - 3'd1;
        end
        if (in_fire && dec_res.valid) begin
          skid <= dec_res;
        end
      end
    end
  end

endmodule

FILE: sv/utf8d_decode.sv
// Decode logic: next sequence state and result entry for one input byte.
module utf8d_decode import utf8d_pkg::*; (
  input  logic        [7:0] in_byte,
  input  logic              in_last,
  input  logic              allow_long,
  input  u8d_state_t        cur,
  output u8d_state_t        nxt,
  output u8d_result_t       res
);

  logic [CntWidth-1:0] held_clamped;

  always_comb begin
    nxt = cur;
    res = '0;
    held_clamped = '0;
    if (cur.bytes_still_needed == '0) begin
      if (in_byte[7] == 1'b0) begin
        res.valid      = 1'b1;
        res.code_point = {{(CpWidth-8){1'b0}}, in_byte};
        res.count      = 3'd1;
        res.last       = in_last;
      end else if (in_byte[7:5] == 3'b110) begin
        nxt = '{{{(CpWidth-5){1'b0}}, in_byte[4:0]}, 3'd1, 3'd1};
      end else if (in_byte[7:4] == 4'b1110) begin
        nxt = '{{{(CpWidth-4){1'b0}}, in_byte[3:0]}, 3'd2, 3'd1};
      end else if (in_byte[7:3] == 5'b11110) begin
        nxt = '{{{(CpWidth-3){1'b0}}, in_byte[2:0]}, 3'd3, 3'd1};
      end else if (allow_long && in_byte[7:2] == 6'b111110) begin
        nxt = '{{{(CpWidth-2){1'b0}}, in_byte[1:0]}, 3'd4, 3'd1};
      end else if (allow_long && in_byte[7:1] == 7'b1111110) begin
        nxt = '{{{(CpWidth-1){1'b0}}, in_byte[0]}, 3'd5, 3'd1};
      end else begin
        res.valid     = 1'b1;
        res.malformed = 1'b1;
        res.count     = 3'd1;
        res.last      = in_last;
      end
    end else begin
      nxt.partial_value      = {cur.partial_value[CpWidth-7:0], in_byte[5:0]};
      nxt.bytes_still_needed = cur.bytes_still_needed - 3'd1;
      nxt.bytes_held         = cur.bytes_held + 3'd1;
      if (nxt.bytes_still_needed == '0) begin
        res.valid      = 1'b1;
        res.code_point = nxt.partial_value;
        res.count      = 3'd1;
        res.last       = in_last;
        nxt            = '0;
      end
    end

    if (in_last) begin
      if (nxt.bytes_still_needed != '0) begin
        held_clamped = nxt.bytes_held;
        if (held_clamped == '0) begin
          held_clamped = 3'd1;
        end
        if (held_clamped > MaxErrItems) begin
          held_clamped = MaxErrItems;
        end
        res.valid      = 1'b1;
        res.code_point = '0;
        res.malformed  = 1'b1;
        res.last       = 1'b1;
        res.count      = held_clamped;
      end
      nxt = '0;
    end
  end

endmodule
